// File: rtl/kcv_pkg.sv
`default_nettype none
package kcv_pkg;
    localparam int DW = 32;
    localparam int FB = 16;
    localparam int NREG = 7;
    localparam int QW = 48;

    localparam logic [2:0] REG_DT    = 3'd0;
    localparam logic [2:0] REG_Q00   = 3'd1;
    localparam logic [2:0] REG_Q01   = 3'd2;
    localparam logic [2:0] REG_Q10   = 3'd3;
    localparam logic [2:0] REG_Q11   = 3'd4;
    localparam logic [2:0] REG_SIG   = 3'd5;
    localparam logic [2:0] REG_START = 3'd6;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_DIVWAIT,
        ST_OUT
    } t_state;

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

    // saturate a wide signed value to DW bits
    function automatic logic [DW:0] sat_wide(input logic signed [DW+1:0] v);
        logic [DW:0] r;
        if (v > $signed({{2{1'b0}}, VMAX})) begin
            r = {1'b1, VMAX};
        end else if (v < $signed({{2{1'b1}}, VMIN})) begin
            r = {1'b1, VMIN};
        end else begin
            r = {1'b0, v[DW-1:0]};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/kcv_alu.sv
`default_nettype none
// One add/sub/multiply unit; product rounded half away from zero and saturated.
module kcv_alu (
    input  wire logic                        i_clk,
    input  wire kcv_pkg::t_op                i_op,
    input  wire logic signed [kcv_pkg::DW-1:0] i_a,
    input  wire logic signed [kcv_pkg::DW-1:0] i_b,
    output logic signed [kcv_pkg::DW-1:0]      o_y,
    output logic                             o_sat
);
    logic [kcv_pkg::DW-1:0]   w_ma;
    logic [kcv_pkg::DW-1:0]   w_mb;
    logic [2*kcv_pkg::DW-1:0] w_p;
    logic [2*kcv_pkg::DW-1:0] w_pr;
    logic                     w_neg;
    logic [kcv_pkg::DW:0]     w_res;
    logic [kcv_pkg::DW-1:0]   w_lim;
    logic [2*kcv_pkg::DW-kcv_pkg::FB-1:0] w_sh;

    always_comb begin
        w_ma  = i_a[kcv_pkg::DW-1] ? -i_a : i_a;
        w_mb  = i_b[kcv_pkg::DW-1] ? -i_b : i_b;
        w_neg = i_a[kcv_pkg::DW-1] ^ i_b[kcv_pkg::DW-1];
        w_p   = w_ma * w_mb;
        w_pr  = w_p + ((2*kcv_pkg::DW)'(1) << (kcv_pkg::FB-1));
        w_sh  = w_pr[2*kcv_pkg::DW-1:kcv_pkg::FB];
        w_lim = w_neg ? kcv_pkg::VMIN : kcv_pkg::VMAX;
        unique case (i_op)
            kcv_pkg::OP_ADD: w_res = kcv_pkg::sat_wide(
                (kcv_pkg::DW+2)'(i_a) + (kcv_pkg::DW+2)'(i_b));
            kcv_pkg::OP_SUB: w_res = kcv_pkg::sat_wide(
                (kcv_pkg::DW+2)'(i_a) - (kcv_pkg::DW+2)'(i_b));
            kcv_pkg::OP_MUL: begin
                if (w_p > w_pr || w_sh > {{(kcv_pkg::DW-kcv_pkg::FB){1'b0}}, w_lim}) begin
                    w_res = {1'b1, w_neg ? kcv_pkg::VMIN : kcv_pkg::VMAX};
                end else begin
                    w_res = {1'b0, w_neg ? -w_sh[kcv_pkg::DW-1:0] : w_sh[kcv_pkg::DW-1:0]};
                end
            end
            default: w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_y   <= w_res[kcv_pkg::DW-1:0];
        o_sat <= w_res[kcv_pkg::DW];
    end
endmodule
`default_nettype wire

// File: rtl/kcv_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle: trunc(a * 2^FB / b), saturated.
module kcv_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [kcv_pkg::DW-1:0] i_a,
    input  wire logic signed [kcv_pkg::DW-1:0] i_b,
    output logic                               o_done,
    output logic signed [kcv_pkg::DW-1:0]      o_q,
    output logic                               o_sat
);
    localparam int NW = kcv_pkg::DW + kcv_pkg::FB;
    logic [NW-1:0]          r_num;
    logic [NW-1:0]          r_quo;
    logic [kcv_pkg::DW:0]   r_rem;
    logic [kcv_pkg::DW-1:0] r_den;
    logic                   r_neg;
    logic [$clog2(NW+1)-1:0] r_cnt;
    logic                   r_busy;
    logic [kcv_pkg::DW:0]   w_rem;
    logic [kcv_pkg::DW-1:0] w_lim;

    assign w_rem = {r_rem[kcv_pkg::DW-1:0], r_num[NW-1]};
    assign w_lim = r_neg ? kcv_pkg::VMIN : kcv_pkg::VMAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= {(i_a[kcv_pkg::DW-1] ? -i_a : i_a), {kcv_pkg::FB{1'b0}}};
                r_den  <= i_b[kcv_pkg::DW-1] ? -i_b : i_b;
                r_neg  <= i_a[kcv_pkg::DW-1] ^ i_b[kcv_pkg::DW-1];
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (w_rem >= {1'b0, r_den}) begin
                    r_rem <= w_rem - {1'b0, r_den};
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem;
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(NW+1))'(NW-1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_quo > {{kcv_pkg::FB{1'b0}}, w_lim}) begin
            o_q   = w_lim;
            o_sat = 1'b1;
        end else begin
            o_q   = r_neg ? -r_quo[kcv_pkg::DW-1:0] : r_quo[kcv_pkg::DW-1:0];
            o_sat = 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: rtl/kalman_cv_tracker.sv
`default_nettype none
// Constant-velocity two-state Kalman tracker, signed Q16.16.
// Input channel s_axis: tdata = measurement (32 bits), tuser = restart.
//   restart=1 reloads start_position, zero velocity and zero covariance first.
// Output channel m_axis: tdata = position_estimate, tuser = saturated.
// Config channel: i_cfg_valid/o_cfg_ready with register index and data;
//   0 dt, 1..4 Q00,Q01,Q10,Q11, 5 sigma, 6 start_position. Write when idle.
// One item at a time: 29 ALU operations on one shared add/sub/multiply unit
//   (issue, then write back) plus two restoring divisions of 48 quotient bits
//   each, then an output step; with a zero gain divisor the divisions are
//   skipped, the gains set to zero and the result flagged saturated.
//   s_axis_tready is high only while idle: no new item before the result is loaded.
// The result waits in an output register until taken; the next item can be
//   accepted and computed meanwhile, and its result is held back (the block
//   stays busy) while m_axis_tready keeps the earlier result waiting.
// Reset (synchronous, active low) restores register defaults (dt = 1.0,
//   sigma = 1.0, others 0) and clears state and covariance.
module kalman_cv_tracker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] measurement
    input  wire logic        s_axis_tuser,   // [0] restart
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] position_estimate
    output logic             m_axis_tuser,   // [0] saturated
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int DW = kcv_pkg::DW;
    typedef logic signed [DW-1:0] t_w;

    // register file slots
    localparam logic [3:0] V_P00 = 4'd0, V_P01 = 4'd1, V_P10 = 4'd2, V_P11 = 4'd3,
        V_POS = 4'd4, V_VEL = 4'd5, V_T0 = 4'd6, V_T1 = 4'd7, V_S00 = 4'd8,
        V_S01 = 4'd9, V_S10 = 4'd10, V_S11 = 4'd11, V_K0 = 4'd12, V_K1 = 4'd13,
        V_DEN = 4'd14, V_T2 = 4'd15;
    // operand sources beyond the register file
    localparam logic [4:0] X_DT = 5'd16, X_SIG = 5'd17, X_Z = 5'd18, X_Q00 = 5'd19,
        X_Q01 = 5'd20, X_Q10 = 5'd21, X_Q11 = 5'd22;

    typedef struct packed {
        kcv_pkg::t_op op;
        logic [4:0]   a;
        logic [4:0]   b;
        logic [3:0]   d;
    } t_uop;

    function automatic t_uop prog(input logic [4:0] pc);
        t_uop u;
        unique case (pc)
            5'd0:  u = '{kcv_pkg::OP_MUL, X_DT, {1'b0, V_P10}, V_T0};
            5'd1:  u = '{kcv_pkg::OP_ADD, {1'b0, V_P00}, {1'b0, V_T0}, V_T0};   // m00
            5'd2:  u = '{kcv_pkg::OP_MUL, X_DT, {1'b0, V_P11}, V_T1};
            5'd3:  u = '{kcv_pkg::OP_ADD, {1'b0, V_P01}, {1'b0, V_T1}, V_T1};   // m01
            5'd4:  u = '{kcv_pkg::OP_MUL, {1'b0, V_T1}, X_DT, V_S00};
            5'd5:  u = '{kcv_pkg::OP_ADD, {1'b0, V_T0}, {1'b0, V_S00}, V_S00};
            5'd6:  u = '{kcv_pkg::OP_ADD, {1'b0, V_S00}, X_Q00, V_S00};
            5'd7:  u = '{kcv_pkg::OP_ADD, {1'b0, V_T1}, X_Q01, V_S01};
            5'd8:  u = '{kcv_pkg::OP_MUL, {1'b0, V_P11}, X_DT, V_S10};
            5'd9:  u = '{kcv_pkg::OP_ADD, {1'b0, V_P10}, {1'b0, V_S10}, V_S10};
            5'd10: u = '{kcv_pkg::OP_ADD, {1'b0, V_S10}, X_Q10, V_S10};
            5'd11: u = '{kcv_pkg::OP_ADD, {1'b0, V_P11}, X_Q11, V_S11};
            5'd12: u = '{kcv_pkg::OP_MUL, X_SIG, X_SIG, V_DEN};
            5'd13: u = '{kcv_pkg::OP_ADD, {1'b0, V_S00}, {1'b0, V_DEN}, V_DEN};
            // after divisions
            5'd14: u = '{kcv_pkg::OP_MUL, {1'b0, V_K0}, {1'b0, V_S00}, V_T0};
            5'd15: u = '{kcv_pkg::OP_SUB, {1'b0, V_S00}, {1'b0, V_T0}, V_P00};
            5'd16: u = '{kcv_pkg::OP_MUL, {1'b0, V_K0}, {1'b0, V_S01}, V_T0};
            5'd17: u = '{kcv_pkg::OP_SUB, {1'b0, V_S01}, {1'b0, V_T0}, V_P01};
            5'd18: u = '{kcv_pkg::OP_MUL, {1'b0, V_K1}, {1'b0, V_S00}, V_T0};
            5'd19: u = '{kcv_pkg::OP_SUB, {1'b0, V_S10}, {1'b0, V_T0}, V_P10};
            5'd20: u = '{kcv_pkg::OP_MUL, {1'b0, V_K1}, {1'b0, V_S01}, V_T0};
            5'd21: u = '{kcv_pkg::OP_SUB, {1'b0, V_S11}, {1'b0, V_T0}, V_P11};
            5'd22: u = '{kcv_pkg::OP_MUL, X_DT, {1'b0, V_VEL}, V_T0};
            5'd23: u = '{kcv_pkg::OP_ADD, {1'b0, V_POS}, {1'b0, V_T0}, V_T0};  // pred
            5'd24: u = '{kcv_pkg::OP_SUB, X_Z, {1'b0, V_T0}, V_T1};            // innov
            5'd25: u = '{kcv_pkg::OP_MUL, {1'b0, V_K0}, {1'b0, V_T1}, V_T2};
            5'd26: u = '{kcv_pkg::OP_ADD, {1'b0, V_T0}, {1'b0, V_T2}, V_POS};
            5'd27: u = '{kcv_pkg::OP_MUL, {1'b0, V_K1}, {1'b0, V_T1}, V_T2};
            5'd28: u = '{kcv_pkg::OP_ADD, {1'b0, V_VEL}, {1'b0, V_T2}, V_VEL};
            default: u = '{kcv_pkg::OP_ADD, {1'b0, V_T2}, {1'b0, V_T2}, V_T2};
        endcase
        return u;
    endfunction

    localparam logic [4:0] PC_DIV  = 5'd14;
    localparam logic [4:0] PC_LAST = 5'd28;

    logic [30:0] r_dt, r_sig;
    t_w          r_q00, r_q01, r_q10, r_q11, r_start;
    t_w          r_v [16];
    t_w          r_z;
    logic        r_satf;
    kcv_pkg::t_state r_state, n_state;
    logic [4:0]  r_pc;
    logic        r_ph;      // 0: issue, 1: write back
    logic        r_dsel;    // 0: K0, 1: K1
    logic        r_ovalid;
    t_w          r_odata;
    logic        r_osat;

    t_uop  w_u;
    t_w    w_a, w_b, w_y;
    logic  w_ysat;
    logic  w_dstart;
    logic  w_ddone;
    t_w    w_dq;
    logic  w_dsat;
    logic  w_take;
    logic  w_oload;

    function automatic t_w src(input logic [4:0] s, input t_w v [16], input logic [30:0] dt,
        input logic [30:0] sg, input t_w z, input t_w q0, input t_w q1, input t_w q2,
        input t_w q3);
        t_w r;
        unique case (s)
            X_DT:  r = {1'b0, dt};
            X_SIG: r = {1'b0, sg};
            X_Z:   r = z;
            X_Q00: r = q0;
            X_Q01: r = q1;
            X_Q10: r = q2;
            X_Q11: r = q3;
            default: r = v[s[3:0]];
        endcase
        return r;
    endfunction

    assign w_u = prog(r_pc);
    assign w_a = src(w_u.a, r_v, r_dt, r_sig, r_z, r_q00, r_q01, r_q10, r_q11);
    assign w_b = src(w_u.b, r_v, r_dt, r_sig, r_z, r_q00, r_q01, r_q10, r_q11);
    assign w_take = s_axis_tvalid && s_axis_tready;
    // output register free or being emptied this cycle
    assign w_oload = (r_state == kcv_pkg::ST_OUT) && (!r_ovalid || m_axis_tready);

    kcv_alu u_alu (
        .i_clk (i_clk),
        .i_op  (w_u.op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_y   (w_y),
        .o_sat (w_ysat)
    );

    kcv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_a     (r_dsel ? r_v[V_S10] : r_v[V_S00]),
        .i_b     (r_v[V_DEN]),
        .o_done  (w_ddone),
        .o_q     (w_dq),
        .o_sat   (w_dsat)
    );

    assign s_axis_tready = (r_state == kcv_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;

    always_comb begin
        n_state  = r_state;
        w_dstart = 1'b0;
        unique case (r_state)
            kcv_pkg::ST_IDLE: if (w_take) n_state = kcv_pkg::ST_RUN;
            kcv_pkg::ST_RUN: begin
                if (r_ph && r_pc == PC_DIV - 5'd1) n_state = kcv_pkg::ST_DIV;
                else if (r_ph && r_pc == PC_LAST) n_state = kcv_pkg::ST_OUT;
            end
            kcv_pkg::ST_DIV: begin
                if (r_v[V_DEN] == '0) begin
                    n_state = kcv_pkg::ST_RUN;
                end else begin
                    w_dstart = 1'b1;
                    n_state  = kcv_pkg::ST_DIVWAIT;
                end
            end
            kcv_pkg::ST_DIVWAIT: begin
                if (w_ddone) n_state = r_dsel ? kcv_pkg::ST_RUN : kcv_pkg::ST_DIV;
            end
            kcv_pkg::ST_OUT: if (w_oload) n_state = kcv_pkg::ST_IDLE;
            default: n_state = kcv_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kcv_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_dt     <= 31'd65536;
            r_sig    <= 31'd65536;
            r_q00    <= '0;
            r_q01    <= '0;
            r_q10    <= '0;
            r_q11    <= '0;
            r_start  <= '0;
            for (int i = 0; i < 16; i++) r_v[i] <= '0;
            r_pc     <= '0;
            r_ph     <= 1'b0;
            r_dsel   <= 1'b0;
            r_satf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    kcv_pkg::REG_DT:    r_dt    <= i_cfg_data[30:0];
                    kcv_pkg::REG_Q00:   r_q00   <= i_cfg_data;
                    kcv_pkg::REG_Q01:   r_q01   <= i_cfg_data;
                    kcv_pkg::REG_Q10:   r_q10   <= i_cfg_data;
                    kcv_pkg::REG_Q11:   r_q11   <= i_cfg_data;
                    kcv_pkg::REG_SIG:   r_sig   <= i_cfg_data[30:0];
                    kcv_pkg::REG_START: r_start <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_oload) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                kcv_pkg::ST_IDLE: begin
                    if (w_take) begin
                        r_z    <= s_axis_tdata;
                        r_pc   <= '0;
                        r_ph   <= 1'b0;
                        r_dsel <= 1'b0;
                        r_satf <= 1'b0;
                        if (s_axis_tuser) begin
                            r_v[V_POS] <= r_start;
                            r_v[V_VEL] <= '0;
                            r_v[V_P00] <= '0;
                            r_v[V_P01] <= '0;
                            r_v[V_P10] <= '0;
                            r_v[V_P11] <= '0;
                        end
                    end
                end
                kcv_pkg::ST_RUN: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_v[w_u.d] <= w_y;
                        r_satf     <= r_satf | w_ysat;
                        if (r_pc == PC_DIV - 5'd1) r_pc <= r_pc + 5'd1;
                        else if (r_pc != PC_LAST) r_pc <= r_pc + 5'd1;
                    end
                end
                kcv_pkg::ST_DIV: begin
                    if (r_v[V_DEN] == '0) begin
                        r_v[V_K0] <= '0;
                        r_v[V_K1] <= '0;
                        r_satf    <= 1'b1;
                    end
                end
                kcv_pkg::ST_DIVWAIT: begin
                    if (w_ddone) begin
                        r_v[r_dsel ? V_K1 : V_K0] <= w_dq;
                        r_satf <= r_satf | w_dsat;
                        r_dsel <= 1'b1;
                    end
                end
                kcv_pkg::ST_OUT: begin
                    if (w_oload) begin
                        r_odata <= r_v[V_POS];
                        r_osat  <= r_satf;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
